@@ hw/rtl/cubic_bezier_forward_difference_core_macros.svh @@
// assertion macros for the cubic bezier forward-difference core
`ifndef CUBIC_BEZIER_FORWARD_DIFFERENCE_CORE_MACROS_SVH
`define CUBIC_BEZIER_FORWARD_DIFFERENCE_CORE_MACROS_SVH
// clocked property on i_clk, held off while reset is low
`define CBFD_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition that must never be seen at a clock edge
`define CBFD_ASSERT_NEVER(label, expr, msg) \
    `CBFD_ASSERT_CLK(label, !(expr), msg)
`endif

@@ hw/rtl/cbfd_pkg.sv @@
// package: shared constants and the controller/datapath command and status types
package cbfd_pkg;

    localparam int MAX_SEGMENTS_DEF = 63;
    localparam int COORD_WIDTH_DEF  = 16;
    // headroom of the per-step quotients over the coordinate width
    localparam int QUO_MARGIN       = 8;

    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] SEG_COUNT_RESET = 6'd10;

    typedef struct packed {
        logic capture;
        logic mul;
        logic num;
        logic load;
        logic step;
        logic fix;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

@@ hw/rtl/cbfd_in_if.sv @@
// input channel: one curve of four 3-d control points
interface cbfd_in_if #(
    parameter int W = cbfd_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] p0_x;
    logic signed [W-1:0] p0_y;
    logic signed [W-1:0] p0_z;
    logic signed [W-1:0] p1_x;
    logic signed [W-1:0] p1_y;
    logic signed [W-1:0] p1_z;
    logic signed [W-1:0] p2_x;
    logic signed [W-1:0] p2_y;
    logic signed [W-1:0] p2_z;
    logic signed [W-1:0] p3_x;
    logic signed [W-1:0] p3_y;
    logic signed [W-1:0] p3_z;

    modport source (
        output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

@@ hw/rtl/cbfd_out_if.sv @@
// output channel: one tessellated curve point
interface cbfd_out_if #(
    parameter int W = cbfd_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic signed [W-1:0] out_z;
    logic                last_point;

    modport source (
        output valid, out_x, out_y, out_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, last_point,
        output ready
    );
endinterface

@@ hw/rtl/cbfd_div_lane.sv @@
// one lane of the set-up divider: restoring floor division by the scale, one bit a cycle
module cbfd_div_lane #(
    parameter int QUO_WIDTH   = cbfd_pkg::COORD_WIDTH_DEF + cbfd_pkg::QUO_MARGIN,
    parameter int SCALE_WIDTH = 21
) (
    input  logic                                 i_clk,
    input  cbfd_pkg::t_cmd                       i_cmd,
    input  logic signed [QUO_WIDTH+SCALE_WIDTH:0] i_num,
    input  logic [SCALE_WIDTH-1:0]               i_scale,
    output logic signed [QUO_WIDTH-1:0]          o_quo,
    output logic [SCALE_WIDTH-1:0]               o_rem
);
    localparam int QW = QUO_WIDTH;
    localparam int SW = SCALE_WIDTH;
    localparam int NW = QW + SW;

    logic          r_neg;
    logic [SW-1:0] r_rem;
    logic [QW-1:0] r_dq;

    logic [NW-1:0] mag;
    logic [SW:0]   rem2;
    logic [SW:0]   dif;
    logic          ge;
    logic          has_rem;

    always_comb begin
        mag     = i_num[NW] ? NW'(-i_num) : NW'(i_num);
        rem2    = {r_rem, r_dq[QW-1]};
        dif     = rem2 - {1'b0, i_scale};
        ge      = (rem2 >= {1'b0, i_scale});
        has_rem = (r_rem != '0);
        // turn the magnitude result into a floor quotient and a non-negative remainder
        if (r_neg) begin
            o_quo = has_rem ? $signed(~r_dq) : $signed(-r_dq);
            o_rem = has_rem ? (i_scale - r_rem) : '0;
        end else begin
            o_quo = $signed(r_dq);
            o_rem = r_rem;
        end
    end

    // quotient is known to fit qw bits, so the top of the dividend starts below the scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_num[NW];
            r_rem <= mag[NW-1:QW];
            r_dq  <= mag[QW-1:0];
        end else if (i_cmd.step) begin
            r_rem <= ge ? dif[SW-1:0] : rem2[SW-1:0];
            r_dq  <= {r_dq[QW-2:0], ge};
        end
    end

endmodule

@@ hw/rtl/cbfd_ctrl.sv @@
// controller: sequences set-up, division and point streaming for one curve at a time
module cbfd_ctrl #(
    parameter int QUO_WIDTH = cbfd_pkg::COORD_WIDTH_DEF + cbfd_pkg::QUO_MARGIN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  cbfd_pkg::t_status i_status,
    output cbfd_pkg::t_cmd    o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    localparam int CNT_W = (QUO_WIDTH > 1) ? $clog2(QUO_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_WIDTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_NUM  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIX  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/cbfd_dp.sv @@
// datapath: difference set-up, divider lanes and quotient/remainder forward differencing
module cbfd_dp #(
    parameter int MAX_SEGMENTS = cbfd_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = cbfd_pkg::COORD_WIDTH_DEF,
    parameter int QUO_WIDTH    = cbfd_pkg::COORD_WIDTH_DEF + cbfd_pkg::QUO_MARGIN
) (
    input  logic                          i_clk,
    input  cbfd_pkg::t_cmd                i_cmd,
    input  logic [cbfd_pkg::CFG_W-1:0]    i_seg_count,
    input  logic signed [COORD_WIDTH-1:0] i_pt [4][3],
    output logic signed [COORD_WIDTH-1:0] o_coord [3],
    output logic                          o_last,
    output cbfd_pkg::t_status             o_status
);
    localparam int CW  = COORD_WIDTH;
    localparam int QW  = QUO_WIDTH;
    localparam int LW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS + 1) : 1;
    localparam int L2W = 2 * LW;
    localparam int L3W = 3 * LW;
    localparam int SW  = $clog2(6 * MAX_SEGMENTS * MAX_SEGMENTS * MAX_SEGMENTS + 1);
    localparam int AW  = CW + 4;
    localparam int BLW = AW + LW + 1;
    localparam int CLW = AW + L2W + 1;
    localparam int ND  = QW + SW + 1;

    localparam logic signed [QW-1:0] C_HI = QW'((1 << (CW - 1)) - 1);
    localparam logic signed [QW-1:0] C_LO = ~C_HI;

    // segment count in force for the curve
    logic [LW-1:0]  r_l;
    logic [L2W-1:0] r_l2;
    logic [L3W-1:0] r_l3;
    logic [SW-1:0]  r_s;
    logic [LW-1:0]  r_idx;

    logic signed [AW-1:0]  r_a   [3];
    logic signed [AW-1:0]  r_b   [3];
    logic signed [AW-1:0]  r_c   [3];
    logic signed [BLW-1:0] r_bl  [3];
    logic signed [CLW-1:0] r_cl2 [3];
    logic signed [ND-1:0]  r_n1  [3];
    logic signed [ND-1:0]  r_n2  [3];
    logic signed [ND-1:0]  r_n3  [3];

    // each accumulator held as quotient and remainder of the scale
    logic signed [QW-1:0] r_pq  [3];
    logic [SW-1:0]        r_pr  [3];
    logic signed [QW-1:0] r_d1q [3];
    logic [SW-1:0]        r_d1r [3];
    logic signed [QW-1:0] r_d2q [3];
    logic [SW-1:0]        r_d2r [3];
    logic signed [QW-1:0] r_d3q [3];
    logic [SW-1:0]        r_d3r [3];

    logic [LW-1:0]        l_clamped;
    logic signed [AW-1:0] e0 [3];
    logic signed [AW-1:0] e1 [3];
    logic signed [AW-1:0] e2 [3];
    logic signed [AW-1:0] e3 [3];
    logic signed [AW-1:0] t_ab [3];
    logic signed [AW-1:0] u_ab [3];
    logic signed [AW-1:0] v_ab [3];
    logic signed [AW-1:0] a_c [3];
    logic signed [AW-1:0] b_c [3];
    logic signed [AW-1:0] c_c [3];
    logic signed [ND-1:0] a_n [3];
    logic signed [ND-1:0] bl_n [3];
    logic signed [ND-1:0] cl_n [3];
    logic signed [ND-1:0] n1_c [3];
    logic signed [ND-1:0] n2_c [3];
    logic signed [ND-1:0] n3_c [3];
    logic [SW-1:0]        l3_e;
    logic [SW-1:0]        s_c;

    logic signed [QW-1:0] lq1 [3];
    logic [SW-1:0]        lr1 [3];
    logic signed [QW-1:0] lq2 [3];
    logic [SW-1:0]        lr2 [3];
    logic signed [QW-1:0] lq3 [3];
    logic [SW-1:0]        lr3 [3];

    logic                 half [3];
    logic signed [QW-1:0] rnd  [3];

    function automatic logic [QW+SW-1:0] mr_add(
        input logic [QW-1:0] qa,
        input logic [SW-1:0] ra,
        input logic [QW-1:0] qb,
        input logic [SW-1:0] rb,
        input logic [SW-1:0] s
    );
        logic [SW:0]   sum;
        logic [SW:0]   dif;
        logic          cy;
        logic [QW-1:0] q;
        sum = {1'b0, ra} + {1'b0, rb};
        dif = sum - {1'b0, s};
        cy  = (sum >= {1'b0, s});
        q   = qa + qb + QW'(cy);
        return {q, cy ? dif[SW-1:0] : sum[SW-1:0]};
    endfunction

    always_comb begin
        if (i_seg_count == '0) begin
            l_clamped = LW'(1);
        end else if (i_seg_count > cbfd_pkg::CFG_W'(MAX_SEGMENTS)) begin
            l_clamped = LW'(MAX_SEGMENTS);
        end else begin
            l_clamped = i_seg_count[LW-1:0];
        end
    end

    // polynomial coefficients a, b, c per axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e0[k]   = AW'(i_pt[0][k]);
            e1[k]   = AW'(i_pt[1][k]);
            e2[k]   = AW'(i_pt[2][k]);
            e3[k]   = AW'(i_pt[3][k]);
            t_ab[k] = e1[k] - e2[k];
            u_ab[k] = e0[k] - (e1[k] <<< 1) + e2[k];
            v_ab[k] = e1[k] - e0[k];
            a_c[k]  = e3[k] - e0[k] + (t_ab[k] <<< 1) + t_ab[k];
            b_c[k]  = (u_ab[k] <<< 1) + u_ab[k];
            c_c[k]  = (v_ab[k] <<< 1) + v_ab[k];
        end
    end

    // scaled differences: d3 = 36a, d2 = 36a + 12bl, d1 = 6a + 6bl + 6cl^2
    always_comb begin
        l3_e = SW'(r_l3);
        s_c  = (l3_e << 2) + (l3_e << 1);
        for (int k = 0; k < 3; k++) begin
            a_n[k]  = ND'(r_a[k]);
            bl_n[k] = ND'(r_bl[k]);
            cl_n[k] = ND'(r_cl2[k]);
            n3_c[k] = (a_n[k] <<< 5) + (a_n[k] <<< 2);
            n2_c[k] = n3_c[k] + (bl_n[k] <<< 3) + (bl_n[k] <<< 2);
            n1_c[k] = (a_n[k] <<< 2) + (a_n[k] <<< 1) + (bl_n[k] <<< 2) + (bl_n[k] <<< 1)
                    + (cl_n[k] <<< 2) + (cl_n[k] <<< 1);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        cbfd_div_lane #(
            .QUO_WIDTH   (QW),
            .SCALE_WIDTH (SW)
        ) u_div1 (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_num   (r_n1[g]),
            .i_scale (r_s),
            .o_quo   (lq1[g]),
            .o_rem   (lr1[g])
        );
        cbfd_div_lane #(
            .QUO_WIDTH   (QW),
            .SCALE_WIDTH (SW)
        ) u_div2 (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_num   (r_n2[g]),
            .i_scale (r_s),
            .o_quo   (lq2[g]),
            .o_rem   (lr2[g])
        );
        cbfd_div_lane #(
            .QUO_WIDTH   (QW),
            .SCALE_WIDTH (SW)
        ) u_div3 (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_num   (r_n3[g]),
            .i_scale (r_s),
            .o_quo   (lq3[g]),
            .o_rem   (lr3[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_l   <= l_clamped;
            r_l2  <= L2W'(l_clamped) * L2W'(l_clamped);
            r_idx <= '0;
            for (int k = 0; k < 3; k++) begin
                r_a[k]  <= a_c[k];
                r_b[k]  <= b_c[k];
                r_c[k]  <= c_c[k];
                r_pq[k] <= QW'(i_pt[0][k]);
                r_pr[k] <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_l3 <= L3W'(r_l2) * L3W'(r_l);
            for (int k = 0; k < 3; k++) begin
                r_bl[k]  <= BLW'(r_b[k]) * BLW'($signed({1'b0, r_l}));
                r_cl2[k] <= CLW'(r_c[k]) * CLW'($signed({1'b0, r_l2}));
            end
        end
        if (i_cmd.num) begin
            r_s <= s_c;
            for (int k = 0; k < 3; k++) begin
                r_n1[k] <= n1_c[k];
                r_n2[k] <= n2_c[k];
                r_n3[k] <= n3_c[k];
            end
        end
        if (i_cmd.fix) begin
            for (int k = 0; k < 3; k++) begin
                r_d1q[k] <= lq1[k];
                r_d1r[k] <= lr1[k];
                r_d2q[k] <= lq2[k];
                r_d2r[k] <= lr2[k];
                r_d3q[k] <= lq3[k];
                r_d3r[k] <= lr3[k];
            end
        end
        if (i_cmd.adv) begin
            r_idx <= r_idx + 1'b1;
            for (int k = 0; k < 3; k++) begin
                {r_pq[k], r_pr[k]}   <= mr_add(r_pq[k], r_pr[k], r_d1q[k], r_d1r[k], r_s);
                {r_d1q[k], r_d1r[k]} <= mr_add(r_d1q[k], r_d1r[k], r_d2q[k], r_d2r[k], r_s);
                {r_d2q[k], r_d2r[k]} <= mr_add(r_d2q[k], r_d2r[k], r_d3q[k], r_d3r[k], r_s);
            end
        end
    end

    // round half up: add one when the remainder reaches half the scale
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            half[k] = (r_pr[k] >= (r_s >> 1));
            rnd[k]  = r_pq[k] + $signed(QW'(half[k]));
            if (rnd[k] > C_HI) begin
                o_coord[k] = C_HI[CW-1:0];
            end else if (rnd[k] < C_LO) begin
                o_coord[k] = C_LO[CW-1:0];
            end else begin
                o_coord[k] = rnd[k][CW-1:0];
            end
        end
    end

    assign o_last        = (r_idx == r_l);
    assign o_status.last = o_last;

endmodule

@@ hw/rtl/cubic_bezier_forward_difference_core.sv @@
// Cubic Bezier tessellator by exact forward differencing.
// Input channel i_in takes one curve per item: four control points, x/y/z each,
// signed fixed point. Output channel o_out gives L+1 points per curve,
// at t = i/L for i = 0..L, with last_point set on the point at t = 1.
// The segment count L is written through i_cfg_wr_en/i_cfg_wr_data; the user must write
// it only while the core is idle, which the core does not enforce; zero counts as one and
// values above MAX_SEGMENTS saturate there. One curve is handled at a time. After an
// item is accepted the core computes the difference coefficients, then nine divider
// lanes run one quotient bit a cycle, and a fix-up step follows before the first point
// is valid. Points then leave at one per cycle while the receiver is ready, and
// i_in.ready is high again in the cycle after the last point is taken.
// A stalled receiver holds the current point and freezes the accumulators.
// Synchronous active-low reset returns the core to idle and the count to 10.
`include "cubic_bezier_forward_difference_core_macros.svh"

module cubic_bezier_forward_difference_core #(
    parameter int MAX_SEGMENTS = cbfd_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = cbfd_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [cbfd_pkg::CFG_W-1:0]     i_cfg_wr_data,
    cbfd_in_if.sink                        i_in,
    cbfd_out_if.source                     o_out
);
    localparam int QW = COORD_WIDTH + cbfd_pkg::QUO_MARGIN;

    logic [cbfd_pkg::CFG_W-1:0]    r_seg_count;
    cbfd_pkg::t_cmd                cmd;
    cbfd_pkg::t_status             status;
    logic signed [COORD_WIDTH-1:0] pt    [4][3];
    logic signed [COORD_WIDTH-1:0] coord [3];
    logic                          last;
    logic                          in_ready;
    logic                          out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= cbfd_pkg::SEG_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_seg_count <= i_cfg_wr_data;
        end
    end

    assign pt[0][0] = i_in.p0_x;
    assign pt[0][1] = i_in.p0_y;
    assign pt[0][2] = i_in.p0_z;
    assign pt[1][0] = i_in.p1_x;
    assign pt[1][1] = i_in.p1_y;
    assign pt[1][2] = i_in.p1_z;
    assign pt[2][0] = i_in.p2_x;
    assign pt[2][1] = i_in.p2_y;
    assign pt[2][2] = i_in.p2_z;
    assign pt[3][0] = i_in.p3_x;
    assign pt[3][1] = i_in.p3_y;
    assign pt[3][2] = i_in.p3_z;

    cbfd_ctrl #(
        .QUO_WIDTH (QW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    cbfd_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_WIDTH  (COORD_WIDTH),
        .QUO_WIDTH    (QW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_seg_count (r_seg_count),
        .i_pt        (pt),
        .o_coord     (coord),
        .o_last      (last),
        .o_status    (status)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = out_valid;
    assign o_out.out_x      = coord[0];
    assign o_out.out_y      = coord[1];
    assign o_out.out_z      = coord[2];
    assign o_out.last_point = last;

    // one curve in flight: no new item while points are being offered
    `CBFD_ASSERT_NEVER(a_single_curve, i_in.ready && o_out.valid, "input open while streaming")
    // the core frees up right after the final point is taken
    `CBFD_ASSERT_CLK(a_free_after_last, (o_out.valid && o_out.ready && o_out.last_point) |=> i_in.ready, "not idle after last point")
    // an accepted curve blocks the input in the next cycle
    `CBFD_ASSERT_CLK(a_busy_after_accept, (i_in.valid && i_in.ready) |=> !i_in.ready, "input still open after accept")

endmodule
